[sv/rss_pkg.sv]
// shared types and constants for the residual stream statistics block
package rss_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int SUM_W      = 40;
  localparam int SQ_W       = 63;
  localparam int CNT_W      = 17;
  localparam int OUT_W      = 24;
  localparam int MAX_ITEMS  = 65536;
  localparam int PROD_W     = 2 * SUM_W - 2;
  localparam int ROOT_W     = 64;
  localparam int MUL_STEPS  = SUM_W;
  localparam int ROOT_STEPS = ROOT_W / 2;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;
  localparam int STEP_W     = 7;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic [OUT_W-1:0]        peak;
    logic [CNT_W-1:0]        cnt;
    logic                    ovf;
  } snap_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] mean;
    logic [OUT_W-1:0]        rms;
    logic [OUT_W-1:0]        peak;
    logic [OUT_W-1:0]        sd;
    logic [CNT_W-1:0]        cnt;
    logic                    ovf;
  } res_t;

endpackage

[sv/rss_front.sv]
// front end: sample magnitude stage and running accumulators
module rss_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc_vld,
  input  logic signed [rss_pkg::SAMPLE_W-1:0] residual,
  input  logic                                last,
  output logic                                snap_push,
  output rss_pkg::snap_t                      snap
);

  logic                            s1_vld_r;
  logic [rss_pkg::SAMPLE_W-1:0]    s1_mag_r;
  logic                            s1_neg_r;
  logic                            s1_last_r;
  logic signed [rss_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [rss_pkg::SQ_W-1:0]        sumsq_r, sumsq_nxt;
  logic [rss_pkg::OUT_W-1:0]       peak_r, peak_nxt;
  logic [rss_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [rss_pkg::SAMPLE_W-1:0]    mag;
  logic [2*rss_pkg::SAMPLE_W-1:0]  sq;
  logic signed [rss_pkg::SUM_W-1:0] mag_ext;
  logic                            sat;

  assign mag     = residual[rss_pkg::SAMPLE_W-1] ? (~residual + 1'b1) : residual;
  assign sq      = s1_mag_r * s1_mag_r;
  assign mag_ext = {{(rss_pkg::SUM_W-rss_pkg::SAMPLE_W){1'b0}}, s1_mag_r};
  assign sat     = (cnt_r >= rss_pkg::CNT_W'(rss_pkg::MAX_ITEMS));

  always_comb begin
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    peak_nxt  = peak_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    if (s1_vld_r) begin
      if (sat) begin
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt   = s1_neg_r ? (sum_r - mag_ext) : (sum_r + mag_ext);
        sumsq_nxt = sumsq_r + {{(rss_pkg::SQ_W-2*rss_pkg::SAMPLE_W){1'b0}}, sq};
        if (s1_mag_r > peak_r) peak_nxt = s1_mag_r;
        cnt_nxt   = cnt_r + 1'b1;
      end
    end
  end

  assign snap_push  = s1_vld_r & s1_last_r;
  assign snap.sum   = sum_nxt;
  assign snap.sumsq = sumsq_nxt;
  assign snap.peak  = peak_nxt;
  assign snap.cnt   = cnt_nxt;
  assign snap.ovf   = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      sum_r    <= '0;
      sumsq_r  <= '0;
      peak_r   <= '0;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      s1_vld_r <= acc_vld;
      if (snap_push) begin
        // set closes, start the next one from zero
        sum_r   <= '0;
        sumsq_r <= '0;
        peak_r  <= '0;
        cnt_r   <= '0;
        ovf_r   <= 1'b0;
      end else begin
        sum_r   <= sum_nxt;
        sumsq_r <= sumsq_nxt;
        peak_r  <= peak_nxt;
        cnt_r   <= cnt_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_mag_r  <= mag;
    s1_neg_r  <= residual[rss_pkg::SAMPLE_W-1];
    s1_last_r <= last;
  end

endmodule

[sv/rss_queue.sv]
// short queue of finished set snapshots between front and back
module rss_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  rss_pkg::snap_t            wdata,
  input  logic                      pop,
  output logic                      vld,
  output rss_pkg::snap_t            rdata,
  output logic [rss_pkg::Q_AW:0]    count
);

  rss_pkg::snap_t              mem [rss_pkg::Q_DEPTH];
  logic [rss_pkg::Q_AW-1:0]    wr_r, rd_r;
  logic [rss_pkg::Q_AW:0]      cnt_r;
  logic                        do_pop;

  assign do_pop = pop & (cnt_r != '0);
  assign vld    = (cnt_r != '0);
  assign rdata  = mem[rd_r];
  assign count  = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + {{rss_pkg::Q_AW{1'b0}}, push} - {{rss_pkg::Q_AW{1'b0}}, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= wdata;
  end

endmodule

[sv/rss_back.sv]
// back end: sequencer with serial multiplier and shared divider and square root
module rss_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           snap_vld,
  input  rss_pkg::snap_t snap,
  output logic           snap_pop,
  input  logic           res_pop,
  output logic           res_vld,
  output rss_pkg::res_t  res
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIV_SQ, ST_ROOT_RMS, ST_DIV_SQN, ST_DIV_VAR,
    ST_ROOT_SD, ST_DIV_MEAN, ST_HOLD
  } state_t;

  state_t                        state_r;
  logic [rss_pkg::STEP_W-1:0]    step_r;
  logic                          sneg_r;
  logic [rss_pkg::SUM_W-1:0]     s_r;
  logic [rss_pkg::SQ_W-1:0]      sumsq_r;
  logic [rss_pkg::OUT_W-1:0]     peak_r;
  logic [rss_pkg::CNT_W-1:0]     n_r;
  logic                          ovf_r;
  logic [rss_pkg::SUM_W-1:0]     mpl_r;
  logic [rss_pkg::PROD_W-1:0]    mcand_r, prod_r;
  logic [rss_pkg::PROD_W-1:0]    dq_r;
  logic [rss_pkg::CNT_W-1:0]     rem_r, dvs_r;
  logic [rss_pkg::ROOT_W-1:0]    x_r, rt_r, bit_r;
  logic [rss_pkg::OUT_W-1:0]     rms_r, sd_r, mean_r;
  logic                          res_vld_r;
  rss_pkg::res_t                 res_r;

  logic [rss_pkg::CNT_W:0]       rem_sh;
  logic                          div_ge;
  logic [rss_pkg::CNT_W-1:0]     rem_nxt;
  logic [rss_pkg::PROD_W-1:0]    dq_nxt;
  logic [rss_pkg::ROOT_W-1:0]    rt_sum, x_nxt, rt_nxt;
  logic                          rt_ge;
  logic [rss_pkg::SUM_W-1:0]     s_abs;
  logic [rss_pkg::SQ_W-1:0]      num;
  logic [rss_pkg::CNT_W-1:0]     dvs_var;
  logic [rss_pkg::OUT_W-1:0]     q_lo;
  logic                          div_done, root_done;
  logic                          res_load;

  // restoring division, one quotient bit per step
  assign rem_sh  = {rem_r, dq_r[rss_pkg::PROD_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, dvs_r});
  assign rem_nxt = div_ge ? rss_pkg::CNT_W'(rem_sh - {1'b0, dvs_r})
                          : rss_pkg::CNT_W'(rem_sh);
  assign dq_nxt  = {dq_r[rss_pkg::PROD_W-2:0], div_ge};
  assign div_done = (step_r == rss_pkg::STEP_W'(rss_pkg::PROD_W - 1));

  // digit-by-digit floor square root, one result bit per step
  assign rt_sum = rt_r + bit_r;
  assign rt_ge  = (x_r >= rt_sum);
  assign x_nxt  = rt_ge ? (x_r - rt_sum) : x_r;
  assign rt_nxt = rt_ge ? ((rt_r >> 1) + bit_r) : (rt_r >> 1);
  assign root_done = (step_r == rss_pkg::STEP_W'(rss_pkg::ROOT_STEPS - 1));

  assign s_abs   = snap.sum[rss_pkg::SUM_W-1] ? rss_pkg::SUM_W'(-snap.sum)
                                              : rss_pkg::SUM_W'(snap.sum);
  assign num     = (sumsq_r > dq_nxt[rss_pkg::SQ_W-1:0])
                   ? (sumsq_r - dq_nxt[rss_pkg::SQ_W-1:0]) : '0;
  assign dvs_var = (n_r > rss_pkg::CNT_W'(1)) ? (n_r - 1'b1) : rss_pkg::CNT_W'(1);
  assign q_lo    = dq_nxt[rss_pkg::OUT_W-1:0];

  // a finished set moves to the output once the previous beat is gone
  assign res_load = (state_r == ST_HOLD) & (~res_vld_r | res_pop);

  assign snap_pop = (state_r == ST_IDLE) & snap_vld;
  assign res_vld  = res_vld_r;
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      res_vld_r <= 1'b0;
      step_r    <= '0;
    end else begin
      res_vld_r <= res_load | (res_vld_r & ~res_pop);
      case (state_r)
        ST_IDLE: begin
          if (snap_vld) begin
            sneg_r  <= snap.sum[rss_pkg::SUM_W-1];
            s_r     <= s_abs;
            sumsq_r <= snap.sumsq;
            peak_r  <= snap.peak;
            n_r     <= snap.cnt;
            ovf_r   <= snap.ovf;
            mpl_r   <= s_abs;
            mcand_r <= rss_pkg::PROD_W'(s_abs);
            prod_r  <= '0;
            step_r  <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mpl_r[0]) prod_r <= prod_r + mcand_r;
          mpl_r   <= mpl_r >> 1;
          mcand_r <= mcand_r << 1;
          if (step_r == rss_pkg::STEP_W'(rss_pkg::MUL_STEPS - 1)) begin
            dq_r    <= rss_pkg::PROD_W'(sumsq_r);
            rem_r   <= '0;
            dvs_r   <= n_r;
            step_r  <= '0;
            state_r <= ST_DIV_SQ;
          end else begin
            step_r  <= step_r + 1'b1;
          end
        end
        ST_DIV_SQ, ST_DIV_SQN, ST_DIV_VAR, ST_DIV_MEAN: begin
          if (div_done) begin
            step_r <= '0;
            case (state_r)
              ST_DIV_SQ: begin
                x_r     <= rss_pkg::ROOT_W'(dq_nxt);
                rt_r    <= '0;
                bit_r   <= rss_pkg::ROOT_W'(1) << (rss_pkg::ROOT_W - 2);
                state_r <= ST_ROOT_RMS;
              end
              ST_DIV_SQN: begin
                // floor(sum^2/n) never exceeds the sum of squares; clamp anyway
                dq_r    <= rss_pkg::PROD_W'(num);
                rem_r   <= '0;
                dvs_r   <= dvs_var;
                state_r <= ST_DIV_VAR;
              end
              ST_DIV_VAR: begin
                x_r     <= rss_pkg::ROOT_W'(dq_nxt);
                rt_r    <= '0;
                bit_r   <= rss_pkg::ROOT_W'(1) << (rss_pkg::ROOT_W - 2);
                state_r <= ST_ROOT_SD;
              end
              default: begin
                mean_r  <= sneg_r ? (~q_lo + 1'b1) : q_lo;
                state_r <= ST_HOLD;
              end
            endcase
          end else begin
            dq_r   <= dq_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r + 1'b1;
          end
        end
        ST_ROOT_RMS, ST_ROOT_SD: begin
          if (root_done) begin
            step_r <= '0;
            dq_r   <= (state_r == ST_ROOT_RMS) ? prod_r : rss_pkg::PROD_W'(s_r);
            rem_r  <= '0;
            dvs_r  <= n_r;
            if (state_r == ST_ROOT_RMS) begin
              rms_r   <= rt_nxt[rss_pkg::OUT_W-1:0];
              state_r <= ST_DIV_SQN;
            end else begin
              sd_r    <= rt_nxt[rss_pkg::OUT_W-1:0];
              state_r <= ST_DIV_MEAN;
            end
          end else begin
            x_r    <= x_nxt;
            rt_r   <= rt_nxt;
            bit_r  <= bit_r >> 2;
            step_r <= step_r + 1'b1;
          end
        end
        ST_HOLD: begin
          if (res_load) begin
            res_r.mean <= mean_r;
            res_r.rms  <= rms_r;
            res_r.peak <= peak_r;
            res_r.sd   <= sd_r;
            res_r.cnt  <= n_r;
            res_r.ovf  <= ovf_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/residual_stream_statistics_top.sv]
// top level of the residual stream statistics block
//
//   channel   beat ports                        handshake
//   input     in_residual, in_last              push / full
//   result    out_mean .. out_overflowed        empty / pop
//
// samples are taken one per cycle while full is low; a set's accumulation takes no extra time
// each closed set then runs through the back end one at a time: the multiplier squares
// the sum, and the one-bit-per-step divider and square root give rms, sd and mean
// up to four closed sets wait in the snapshot queue; full rises once three are waiting
// synchronous active-low reset clears the accumulators, queue and sequencer
module residual_stream_statistics_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic signed [rss_pkg::SAMPLE_W-1:0] in_residual,
  input  logic                                in_last,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [rss_pkg::OUT_W-1:0]    out_mean,
  output logic [rss_pkg::OUT_W-1:0]           out_rms,
  output logic [rss_pkg::OUT_W-1:0]           out_peak_magnitude,
  output logic [rss_pkg::OUT_W-1:0]           out_std_dev,
  output logic [rss_pkg::CNT_W-1:0]           out_sample_count,
  output logic                                out_overflowed
);

  logic                      acc_vld;
  logic                      snap_push, snap_vld, snap_pop, res_vld;
  rss_pkg::snap_t            snap_in, snap_out;
  rss_pkg::res_t             res;
  logic [rss_pkg::Q_AW:0]    q_count;

  // one slot stays free for a set still in the sample stage
  assign full    = (q_count >= (rss_pkg::Q_AW+1)'(rss_pkg::Q_DEPTH - 1));
  assign acc_vld = push & ~full;

  rss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_vld   (acc_vld),
    .residual  (in_residual),
    .last      (in_last),
    .snap_push (snap_push),
    .snap      (snap_in)
  );

  rss_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (snap_push),
    .wdata (snap_in),
    .pop   (snap_pop),
    .vld   (snap_vld),
    .rdata (snap_out),
    .count (q_count)
  );

  rss_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .snap_vld (snap_vld),
    .snap     (snap_out),
    .snap_pop (snap_pop),
    .res_pop  (pop),
    .res_vld  (res_vld),
    .res      (res)
  );

  assign empty              = ~res_vld;
  assign out_mean           = res.mean;
  assign out_rms            = res.rms;
  assign out_peak_magnitude = res.peak;
  assign out_std_dev        = res.sd;
  assign out_sample_count   = res.cnt;
  assign out_overflowed     = res.ovf;

  a_no_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    snap_push |-> (q_count != (rss_pkg::Q_AW+1)'(rss_pkg::Q_DEPTH)))
    else $error("snapshot queue overflow");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_sample_count != '0))
    else $error("result with zero samples");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_overflowed) |->
      (out_sample_count == rss_pkg::CNT_W'(rss_pkg::MAX_ITEMS)))
    else $error("overflow flagged below saturation");

  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_rms <= out_peak_magnitude))
    else $error("rms above peak magnitude");

endmodule

[tb/tb_top.sv]
// testbench for the residual stream statistics block: random sample sets against a predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT = 3000000;

  class stats_scoreboard;
    bit [rss_pkg::SUM_W-1:0]  sum_acc;
    bit [rss_pkg::SQ_W-1:0]   sumsq_acc;
    bit [rss_pkg::OUT_W-1:0]  peak_acc;
    bit [rss_pkg::CNT_W-1:0]  count_acc;
    bit                       ovf_acc;
    rss_pkg::res_t            expected_sets[$];
    int                       errors;

    function new();
      clear_set();
      errors = 0;
    endfunction

    function void clear_set();
      sum_acc = '0;
      sumsq_acc = '0;
      peak_acc = '0;
      count_acc = '0;
      ovf_acc = 1'b0;
    endfunction

    function bit [63:0] floor_root(bit [63:0] x);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function rss_pkg::res_t close_set();
      rss_pkg::res_t r;
      bit [63:0] n, s, q, rem, sq_over_n, num, d, sq;
      bit [rss_pkg::SUM_W-1:0] neg_sum;
      bit sneg;
      n = count_acc;
      sq = sumsq_acc;
      r = '0;
      if (n != 0) begin
        sneg = sum_acc[rss_pkg::SUM_W-1];
        neg_sum = -sum_acc;
        s = sneg ? {24'd0, neg_sum} : {24'd0, sum_acc};
        q = s / n;
        rem = s % n;
        sq_over_n = q * s + (rem * s) / n;
        r.mean = sneg ? -q[rss_pkg::OUT_W-1:0] : q[rss_pkg::OUT_W-1:0];
        r.rms = rss_pkg::OUT_W'(floor_root(sq / n));
        num = sq > sq_over_n ? sq - sq_over_n : 0;
        d = n > 1 ? n - 1 : 1;
        r.sd = rss_pkg::OUT_W'(floor_root(num / d));
      end
      r.peak = peak_acc;
      r.cnt = count_acc;
      r.ovf = ovf_acc;
      return r;
    endfunction

    function void note_sample(bit [rss_pkg::SAMPLE_W-1:0] v, bit lst);
      bit [rss_pkg::OUT_W-1:0] mag;
      bit neg;
      bit [63:0] sqr;
      neg = v[rss_pkg::SAMPLE_W-1];
      mag = neg ? -v : v;
      if (count_acc >= rss_pkg::MAX_ITEMS) begin
        ovf_acc = 1'b1;
      end else begin
        sum_acc = neg ? sum_acc - mag : sum_acc + mag;
        sqr = 64'(mag) * 64'(mag);
        sumsq_acc = sumsq_acc + sqr[rss_pkg::SQ_W-1:0];
        if (mag > peak_acc) peak_acc = mag;
        count_acc = count_acc + 1'b1;
      end
      if (lst) begin
        expected_sets = {expected_sets, close_set()};
        clear_set();
      end
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(rss_pkg::res_t got);
      rss_pkg::res_t want;
      if (expected_sets.size() == 0) begin
        report("unexpected result beat", 0, 0);
        return;
      end
      want = expected_sets.pop_front();
      if (got.mean !== want.mean) report("mean", got.mean, want.mean);
      if (got.rms !== want.rms) report("rms", got.rms, want.rms);
      if (got.peak !== want.peak) report("peak_magnitude", got.peak, want.peak);
      if (got.sd !== want.sd) report("std_dev", got.sd, want.sd);
      if (got.cnt !== want.cnt) report("sample_count", got.cnt, want.cnt);
      if (got.ovf !== want.ovf) report("overflowed", got.ovf, want.ovf);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic signed [rss_pkg::SAMPLE_W-1:0] in_residual = '0;
  logic in_last = 1'b0;
  logic full, empty;
  logic signed [rss_pkg::OUT_W-1:0] out_mean;
  logic [rss_pkg::OUT_W-1:0] out_rms, out_peak_magnitude, out_std_dev;
  logic [rss_pkg::CNT_W-1:0] out_sample_count;
  logic out_overflowed;

  stats_scoreboard sb = new();
  bit quiet_tail = 1'b0;
  bit hold_request = 1'b0;
  int unsigned cycle_count = 0;

  always #4 clk = ~clk;

  residual_stream_statistics_top dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_residual(in_residual), .in_last(in_last),
    .empty(empty), .pop(pop),
    .out_mean(out_mean), .out_rms(out_rms), .out_peak_magnitude(out_peak_magnitude),
    .out_std_dev(out_std_dev), .out_sample_count(out_sample_count),
    .out_overflowed(out_overflowed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task send_sample(logic [rss_pkg::SAMPLE_W-1:0] v, logic lst, bit may_idle);
    int gap;
    in_residual <= v;
    in_last <= lst;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_sample(v, lst);
    if (may_idle && !quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [rss_pkg::SAMPLE_W-1:0] pick_value(int mode,
      logic [rss_pkg::SAMPLE_W-1:0] base);
    case (mode)
      0: return rss_pkg::SAMPLE_W'($urandom);
      1: return $urandom_range(0, 1) ? 24'h800000 : 24'h7fffff;
      2: return rss_pkg::SAMPLE_W'($signed($urandom_range(0, 512)) - 256);
      3: return base;
      default: return $urandom_range(0, 1) ? rss_pkg::SAMPLE_W'($urandom)
                      : base ^ rss_pkg::SAMPLE_W'($urandom_range(0, 15));
    endcase
  endfunction

  task send_set(int len, int mode);
    logic [rss_pkg::SAMPLE_W-1:0] base;
    base = rss_pkg::SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++)
      send_sample(pick_value(mode, base), i == len - 1, 1'b1);
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    int idle_left;
    idle_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty)
        sb.check_result('{out_mean, out_rms, out_peak_magnitude, out_std_dev,
                          out_sample_count, out_overflowed});
      if (hold_request) begin
        pop <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_request = 1'b0;
        pop <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        pop <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(0, 6);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int sent;
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-sample sets at the extremes, zero and minus one
    send_sample(24'h800000, 1'b1, 1'b0);
    send_sample(24'h7fffff, 1'b1, 1'b0);
    send_sample(24'h000000, 1'b1, 1'b0);
    send_sample(24'hffffff, 1'b1, 1'b0);
    // opposite extremes, then two constant sets with zero variance, then plus and minus one
    send_sample(24'h800000, 1'b0, 1'b0);
    send_sample(24'h7fffff, 1'b1, 1'b0);
    for (int i = 0; i < 5; i++) send_sample(24'h123456, i == 4, 1'b0);
    for (int i = 0; i < 4; i++) send_sample(24'hfedcba, i == 3, 1'b0);
    send_sample(24'h000001, 1'b0, 1'b0);
    send_sample(24'hffffff, 1'b1, 1'b0);
    push <= 1'b0;

    // sender pause until the block drains
    wait (sb.expected_sets.size() == 0);
    @(posedge clk);

    // long receiver hold while the sender keeps pushing short sets
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) send_set($urandom_range(1, 3), 0);

    sent = 0;
    while (sent < 1310) begin
      int len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
      if (sent > 1110) quiet_tail = 1'b1;
      send_set(len, $urandom_range(0, 4));
      sent += len;
    end
    push <= 1'b0;

    waited = 0;
    while (sb.expected_sets.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.expected_sets.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
